// File: hw/rtl/rgb32_to_i420_convert_top_assert.svh
// Assertion macros shared by the RGB to I420 converter RTL.
// Depends on nothing; included by the top level only.
`ifndef RGB32_TO_I420_CONVERT_TOP_ASSERT_SVH
`define RGB32_TO_I420_CONVERT_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RGB2I_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rgb2i: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define RGB2I_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rgb2i: next-cycle check failed");

`endif

// File: hw/rtl/rgb2i_pkg.sv
// Package for the RGB to I420 converter: sizes, register indexes, coefficients
// and the types passed between the front, the queue and the back.
// Depends on nothing.
package rgb2i_pkg;

    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = CNT_W + 1;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;
    localparam int PIX_W   = 8;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(768);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam int SUM_Y_W = 15;
    localparam int SUM_C_W = 17;

    localparam int COEF_YR = 33;
    localparam int COEF_YG = 65;
    localparam int COEF_YB = 13;
    localparam int COEF_UR = 38;
    localparam int COEF_UG = 74;
    localparam int COEF_UB = 112;
    localparam int COEF_VR = 112;
    localparam int COEF_VG = 94;
    localparam int COEF_VB = 18;
    localparam int LUMA_OFS   = 16;
    localparam int CHROMA_BIAS = 32768;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             chroma_valid;
        logic             frame_end;
    } pix_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [DIM_W-1:0] effective_size(input logic [CFG_W-1:0] reg_val);
        logic [DIM_W-1:0] eff;
        if (reg_val == '0) begin
            eff = DIM_W'(1);
        end else if (int'(reg_val) > MAX_DIM) begin
            eff = DIM_W'(MAX_DIM);
        end else begin
            eff = DIM_W'(reg_val);
        end
        return eff;
    endfunction

endpackage

// File: hw/rtl/rgb32_to_i420_convert_top.sv
// Top level of the RGB to I420 pixel converter: front, queue and back.
// Depends on rgb2i_pkg, rgb2i_front, rgb2i_fifo, rgb2i_back and the
// assertion macro header.
//
// Pixels arrive on the s_ channel (valid/ready) in raster order, one red,
// green and blue byte each. Every accepted pixel gives exactly one result on
// the m_ channel: a luma sample, a U and V pair flagged by m_chroma_valid on
// even rows and columns (zero otherwise), and m_frame_end on the last pixel.
// The frame size is set through cfg_wr_en, cfg_addr and cfg_wr_data by the
// user only while the block is idle, which the block does not enforce;
// index 0 is the width, index 1 the height. One pixel is accepted per clock
// while the queue is not full. A pixel goes from the queue through the
// weighted-sum stage to the output register, where its result can be taken.
// The four-entry queue decouples input from output, so s_ready falls only
// once it is full while m_ready is low.
// On reset the queue and pipeline are emptied, the row and column counters
// return to zero and the frame size returns to 1024 by 768.
`include "rgb32_to_i420_convert_top_assert.svh"
module rgb32_to_i420_convert_top
    import rgb2i_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_red,
    input  logic [PIX_W-1:0] s_green,
    input  logic [PIX_W-1:0] s_blue,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_luma,
    output logic [PIX_W-1:0] m_chroma_u,
    output logic [PIX_W-1:0] m_chroma_v,
    output logic             m_chroma_valid,
    output logic             m_frame_end
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    pix_item_t push_item;
    pix_item_t head_item;

    rgb2i_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    rgb2i_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    rgb2i_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_status       (q_status),
        .head_item      (head_item),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_luma         (m_luma),
        .m_chroma_u     (m_chroma_u),
        .m_chroma_v     (m_chroma_v),
        .m_chroma_valid (m_chroma_valid),
        .m_frame_end    (m_frame_end)
    );

    `RGB2I_ASSERT_NOW(a_chroma_zero, aclk, aresetn, m_valid && !m_chroma_valid, m_chroma_u == '0 && m_chroma_v == '0)
    `RGB2I_ASSERT_NOW(a_luma_floor, aclk, aresetn, m_valid, m_luma >= PIX_W'(LUMA_OFS))
    `RGB2I_ASSERT_NOW(a_queue_sane, aclk, aresetn, q_status.full, !q_status.empty && !push)
    `RGB2I_ASSERT_NEXT(a_queue_fills, aclk, aresetn, q_status.empty && push, !q_status.empty)

endmodule

// File: hw/rtl/rgb2i_front.sv
// Front end of the converter: holds the frame size registers, accepts pixels
// and tags each with its chroma sample and end-of-frame flags.
// Depends on rgb2i_pkg.
module rgb2i_front
    import rgb2i_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_red,
    input  logic [PIX_W-1:0] s_green,
    input  logic [PIX_W-1:0] s_blue,
    input  q_status_t        q_status,
    output logic             push,
    output pix_item_t        push_item
);

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [DIM_W-1:0] column_plus;
    logic [DIM_W-1:0] row_plus;
    logic             row_done;
    logic             frame_done;

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    assign width_eff  = effective_size(frame_width_reg);
    assign height_eff = effective_size(frame_height_reg);
    assign column_plus = DIM_W'(column_count_reg) + DIM_W'(1);
    assign row_plus    = DIM_W'(row_count_reg) + DIM_W'(1);
    assign row_done    = column_plus >= width_eff;
    assign frame_done  = row_done && (row_plus >= height_eff);

    always_comb begin
        push_item.red          = s_red;
        push_item.green        = s_green;
        push_item.blue         = s_blue;
        push_item.chroma_valid = !column_count_reg[0] && !row_count_reg[0];
        push_item.frame_end    = frame_done;
    end

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_wr_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (push) begin
            if (row_done) begin
                column_count_next = '0;
                if (frame_done) begin
                    row_count_next = '0;
                end else begin
                    row_count_next = row_plus[CNT_W-1:0];
                end
            end else begin
                column_count_next = column_plus[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

// File: hw/rtl/rgb2i_fifo.sv
// Short queue between the front and the back of the converter.
// Depends on rgb2i_pkg.
module rgb2i_fifo
    import rgb2i_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pix_item_t push_item,
    input  logic      pop,
    output pix_item_t head_item,
    output q_status_t q_status
);

    pix_item_t            entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_status.full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign head_item      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/rgb2i_back.sv
// Back end of the converter: a two-stage pipeline that forms the weighted
// sums and then the Y, U and V samples in the output register.
// Depends on rgb2i_pkg.
module rgb2i_back
    import rgb2i_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  q_status_t        q_status,
    input  pix_item_t        head_item,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_luma,
    output logic [PIX_W-1:0] m_chroma_u,
    output logic [PIX_W-1:0] m_chroma_v,
    output logic             m_chroma_valid,
    output logic             m_frame_end
);

    logic               s1_valid_reg, s1_valid_next;
    logic [SUM_Y_W-1:0] sum_y_reg, sum_y_next;
    logic [SUM_C_W-1:0] sum_u_reg, sum_u_next;
    logic [SUM_C_W-1:0] sum_v_reg, sum_v_next;
    logic               s1_cv_reg;
    logic               s1_fe_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   luma_reg, luma_next;
    logic [PIX_W-1:0]   chroma_u_reg, chroma_u_next;
    logic [PIX_W-1:0]   chroma_v_reg, chroma_v_next;
    logic               chroma_valid_reg;
    logic               frame_end_reg;
    logic               out_adv;
    logic               s1_adv;
    logic [SUM_C_W-1:0] r_ext, g_ext, b_ext;

    assign out_adv = !out_valid_reg || m_ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign pop     = s1_adv && !q_status.empty;

    assign r_ext = SUM_C_W'(head_item.red);
    assign g_ext = SUM_C_W'(head_item.green);
    assign b_ext = SUM_C_W'(head_item.blue);

    always_comb begin
        sum_y_next = SUM_Y_W'(SUM_C_W'(COEF_YR) * r_ext + SUM_C_W'(COEF_YG) * g_ext
                              + SUM_C_W'(COEF_YB) * b_ext);
        sum_u_next = SUM_C_W'(CHROMA_BIAS) + SUM_C_W'(COEF_UB) * b_ext
                     - SUM_C_W'(COEF_UR) * r_ext - SUM_C_W'(COEF_UG) * g_ext;
        sum_v_next = SUM_C_W'(CHROMA_BIAS) + SUM_C_W'(COEF_VR) * r_ext
                     - SUM_C_W'(COEF_VG) * g_ext - SUM_C_W'(COEF_VB) * b_ext;
        s1_valid_next = s1_adv ? !q_status.empty : s1_valid_reg;
    end

    always_comb begin
        luma_next      = sum_y_reg[SUM_Y_W-1:SUM_Y_W-PIX_W] + PIX_W'(LUMA_OFS);
        chroma_u_next  = s1_cv_reg ? sum_u_reg[2*PIX_W-1:PIX_W] : '0;
        chroma_v_next  = s1_cv_reg ? sum_v_reg[2*PIX_W-1:PIX_W] : '0;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            sum_y_reg <= sum_y_next;
            sum_u_reg <= sum_u_next;
            sum_v_reg <= sum_v_next;
            s1_cv_reg <= head_item.chroma_valid;
            s1_fe_reg <= head_item.frame_end;
        end
        if (out_adv && s1_valid_reg) begin
            luma_reg         <= luma_next;
            chroma_u_reg     <= chroma_u_next;
            chroma_v_reg     <= chroma_v_next;
            chroma_valid_reg <= s1_cv_reg;
            frame_end_reg    <= s1_fe_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_luma         = luma_reg;
    assign m_chroma_u     = chroma_u_reg;
    assign m_chroma_v     = chroma_v_reg;
    assign m_chroma_valid = chroma_valid_reg;
    assign m_frame_end    = frame_end_reg;

endmodule

// File: sim/rgb32_to_i420_convert_top_tb.sv
// Self-checking testbench for rgb32_to_i420_convert_top: predicts Y, U, V and
// the frame flags per pixel and compares every result transfer in order.
// Depends on rgb2i_pkg and the converter RTL.
module rgb32_to_i420_convert_top_tb;
    import rgb2i_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);

    localparam int RANDOM_PIXELS  = 1900;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_SPACING   = 900;
    localparam int HOLD_BACKLOG   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 100;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] chroma_v;
        logic             chroma_valid;
        logic             frame_end;
    } yuv_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [IDX_W-1:0] cfg_addr    = '0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [PIX_W-1:0] s_red       = '0;
    logic [PIX_W-1:0] s_green     = '0;
    logic [PIX_W-1:0] s_blue      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [PIX_W-1:0] m_luma;
    logic [PIX_W-1:0] m_chroma_u;
    logic [PIX_W-1:0] m_chroma_v;
    logic             m_chroma_valid;
    logic             m_frame_end;

    pixel_t pixels_pending[$];
    yuv_t   yuv_expected[$];

    logic [CFG_W-1:0] width_reg  = CFG_W'(1024);
    logic [CFG_W-1:0] height_reg = CFG_W'(768);
    int column_next = 0;
    int row_next    = 0;

    int mismatches   = 0;
    int queued       = 0;
    int results_seen = 0;
    int send_gap     = 0;
    int send_quiet   = 0;
    int recv_stall   = 0;
    int recv_quiet   = 0;
    int hold_left    = 0;
    int hold_mark    = 400;
    int idle_cycles  = 0;
    pixel_t next_px;
    yuv_t   want;

    rgb32_to_i420_convert_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_luma         (m_luma),
        .m_chroma_u     (m_chroma_u),
        .m_chroma_v     (m_chroma_v),
        .m_chroma_valid (m_chroma_valid),
        .m_frame_end    (m_frame_end)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] size);
        if (size == '0) begin
            return 1;
        end
        if (int'(size) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(size);
    endfunction

    // Converts one pixel and advances the raster position.
    function automatic yuv_t convert_pixel(input pixel_t px);
        yuv_t res;
        int   r;
        int   g;
        int   b;
        int   w;
        int   h;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        res.luma = PIX_W'(((33 * r + 65 * g + 13 * b) >>> 7) + 16);
        res.chroma_valid = (column_next % 2 == 0) && (row_next % 2 == 0);
        res.chroma_u = '0;
        res.chroma_v = '0;
        if (res.chroma_valid) begin
            res.chroma_u = PIX_W'((-38 * r - 74 * g + 112 * b + 32768) >>> 8);
            res.chroma_v = PIX_W'((112 * r - 94 * g - 18 * b + 32768) >>> 8);
        end
        res.frame_end = 1'b0;
        if (column_next + 1 >= w) begin
            column_next = 0;
            if (row_next + 1 >= h) begin
                row_next = 0;
                res.frame_end = 1'b1;
            end else begin
                row_next = row_next + 1;
            end
        end else begin
            column_next = column_next + 1;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return CFG_W'($urandom_range(1, 9));
        end
        if (r < 88) begin
            return CFG_W'($urandom_range(10, 64));
        end
        if (r < 92) begin
            return '0;
        end
        if (r < 95) begin
            return CFG_W'(MAX_DIM);
        end
        return CFG_W'($urandom_range(MAX_DIM + 1, 8191));
    endfunction

    task automatic queue_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                               input logic [PIX_W-1:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pixels_pending.push_back(px);
        queued++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = val;
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = val;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pixels_pending.size() != 0 || s_valid || yuv_expected.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic check_field(input string name, input int expected_val, input int actual_val);
        if (expected_val != actual_val) begin
            if (mismatches < REPORT_LIMIT) begin
                $display("%0t ns: result %0d %s expected %0d, actual %0d",
                         $time, results_seen, name, expected_val, actual_val);
            end
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                next_px.red   = s_red;
                next_px.green = s_green;
                next_px.blue  = s_blue;
                yuv_expected.push_back(convert_pixel(next_px));
                send_gap = (send_quiet > 0) ? 0 : pick_gap();
            end
            if (send_quiet > 0) begin
                send_quiet--;
            end else if ($urandom_range(0, 199) == 0) begin
                send_quiet = $urandom_range(50, 200);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pixels_pending.size() != 0) begin
                    next_px = pixels_pending.pop_front();
                    s_valid <= 1'b1;
                    s_red   <= next_px.red;
                    s_green <= next_px.green;
                    s_blue  <= next_px.blue;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (yuv_expected.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("%0t ns: result transfer with no pixel outstanding, luma %0d",
                                 $time, m_luma);
                    end
                    mismatches++;
                end else begin
                    want = yuv_expected.pop_front();
                    check_field("luma", int'(want.luma), int'(m_luma));
                    check_field("chroma_u", int'(want.chroma_u), int'(m_chroma_u));
                    check_field("chroma_v", int'(want.chroma_v), int'(m_chroma_v));
                    check_field("chroma_valid", int'(want.chroma_valid),
                                int'(m_chroma_valid));
                    check_field("frame_end", int'(want.frame_end), int'(m_frame_end));
                end
                results_seen++;
            end
            // A long hold-off lets the queue fill so that the input stalls.
            if (hold_left == 0 && results_seen >= hold_mark
                && pixels_pending.size() >= HOLD_BACKLOG) begin
                hold_left = HOLD_CYCLES;
                hold_mark = hold_mark + HOLD_SPACING;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (recv_quiet > 0) begin
                    recv_quiet--;
                end else if ($urandom_range(0, 199) == 0) begin
                    recv_quiet = $urandom_range(50, 200);
                end
                if (recv_stall > 0) begin
                    recv_stall--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    recv_stall = (recv_quiet > 0) ? 0 : pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb32_to_i420_convert_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int k;
        int n;
        int sel;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corners of the colour cube at the reset frame size.
        for (k = 0; k < 8; k++) begin
            queue_pixel((k & 1) ? 8'hFF : 8'h00, (k & 2) ? 8'hFF : 8'h00,
                        (k & 4) ? 8'hFF : 8'h00);
        end
        drain();

        // Shrinking the frame while the column is past the new row end.
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
        for (k = 0; k < 6; k++) begin
            queue_pixel(pick_level(), pick_level(), pick_level());
        end
        drain();

        // A zero size acts as one, so every pixel carries chroma and ends a frame.
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        for (k = 0; k < 8; k++) begin
            queue_pixel((k & 1) ? 8'hFF : 8'h00, (k & 2) ? 8'hFF : 8'h00,
                        (k & 4) ? 8'hFF : 8'h00);
        end
        drain();

        // Oversized sizes clamp to the maximum; writes to spare indexes are dropped.
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, CFG_W'(MAX_DIM + 1));
        write_reg(REG_SPARE_2, CFG_W'(5));
        write_reg(REG_SPARE_3, '1);
        for (k = 0; k < 3; k++) begin
            queue_pixel(pick_level(), pick_level(), pick_level());
        end
        drain();

        while (queued < RANDOM_PIXELS + 25) begin
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
                write_reg(REG_FRAME_WIDTH, pick_dim());
            end
            if (sel < 6 || sel >= 8) begin
                write_reg(REG_FRAME_HEIGHT, pick_dim());
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_W'($urandom_range(0, 8191)));
            end
            n = $urandom_range(1, 120);
            for (k = 0; k < n; k++) begin
                queue_pixel(pick_level(), pick_level(), pick_level());
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0 && yuv_expected.size() == 0) begin
            $display("rgb32_to_i420_convert_top: match");
        end else begin
            $display("rgb32_to_i420_convert_top: mismatch");
        end
        $finish;
    end

endmodule

// File: rgb32_to_i420_convert_top.f
+incdir+hw/rtl
hw/rtl/rgb2i_pkg.sv
hw/rtl/rgb2i_front.sv
hw/rtl/rgb2i_fifo.sv
hw/rtl/rgb2i_back.sv
hw/rtl/rgb32_to_i420_convert_top.sv
sim/rgb32_to_i420_convert_top_tb.sv
